// ===== hdl/icr_pkg.sv =====
// ----------------------------------------------------------------------------
// icr_pkg: IDE controller register block, shared definitions
// Access kinds, register addresses, write masks and register file defaults.
// ----------------------------------------------------------------------------
package icr_pkg;

  localparam int unsigned RegAddrW = 8;
  localparam int unsigned RegDataW = 8;
  localparam int unsigned RegDepth = 1 << RegAddrW;

  typedef logic [RegAddrW-1:0] reg_addr_t;
  typedef logic [RegDataW-1:0] reg_data_t;

  typedef enum logic [2:0] {
    KIND_IDX_WR  = 3'd0,
    KIND_DATA_WR = 3'd1,
    KIND_IDX_RD  = 3'd2,
    KIND_DATA_RD = 3'd3,
    KIND_CFG_WR  = 3'd4,
    KIND_CFG_RD  = 3'd5,
    KIND_IRQ     = 3'd6
  } kind_e;

  // configuration port register indexes
  localparam logic [1:0] CFG_PCI_MODE   = 2'd0;
  localparam logic [1:0] CFG_CHANNELS   = 2'd1;
  localparam logic [1:0] CFG_CHIP_INDEX = 2'd2;

  // register addresses
  localparam reg_addr_t ADDR_CMD      = 8'h04;
  localparam reg_addr_t ADDR_STAT_HI  = 8'h07;
  localparam reg_addr_t ADDR_CTRL     = 8'h50;
  localparam reg_addr_t ADDR_CTRL1    = 8'h51;
  localparam reg_addr_t ADDR_TIM0     = 8'h52;
  localparam reg_addr_t ADDR_TIM1     = 8'h53;
  localparam reg_addr_t ADDR_TIM2     = 8'h54;
  localparam reg_addr_t ADDR_TIM3     = 8'h55;
  localparam reg_addr_t ADDR_TIM4     = 8'h56;
  localparam reg_addr_t ADDR_SEC_EN   = 8'h57;
  localparam reg_addr_t ADDR_TIM5     = 8'h58;
  localparam reg_addr_t ADDR_TIM6     = 8'h59;

  // write masks
  localparam reg_data_t MASK_CTRL1    = 8'h7f;
  localparam reg_data_t MASK_TIMING   = 8'hcf;
  localparam reg_data_t MASK_CMD_WR   = 8'h40;
  localparam reg_data_t MASK_CMD_KEEP = 8'hbf;
  localparam reg_data_t MASK_W1C      = 8'h80;
  localparam reg_data_t MASK_IRQ      = 8'h04;
  localparam reg_data_t READ_IDLE     = 8'hff;

  typedef struct packed {
    logic      en;
    reg_addr_t addr;
    reg_data_t data;
  } wr_req_t;

  // value of a register after reset or a strap change
  function automatic reg_data_t reg_default(reg_addr_t a, logic pci, logic [1:0] chip);
    reg_data_t v;
    v = '0;
    case (a)
      8'h04: v = 8'h01;
      8'h50: v = {3'b000, chip, 3'b000};
      8'h51: v = 8'h40;
      8'h57: v = 8'h01;
      8'h59: v = 8'h40;
      8'h00: v = pci ? 8'had : 8'h00;
      8'h01: v = pci ? 8'h10 : 8'h00;
      8'h02: v = pci ? 8'h01 : 8'h00;
      8'h07: v = pci ? 8'h02 : 8'h00;
      8'h08: v = pci ? 8'h02 : 8'h00;
      8'h0a: v = pci ? 8'h01 : 8'h00;
      8'h0b: v = pci ? 8'h01 : 8'h00;
      8'h3c: v = pci ? 8'h0e : 8'h00;
      8'h3d: v = pci ? 8'h01 : 8'h00;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/icr_ram.sv =====
// ----------------------------------------------------------------------------
// icr_ram: generic single-write, single-read RAM
// Registered read with read enable; read during write returns old data.
// ----------------------------------------------------------------------------
module icr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/icr_regfile.sv =====
// ----------------------------------------------------------------------------
// icr_regfile: 256-byte register file
// RAM plus per-entry valid bits; an unwritten entry reads its default value.
// ----------------------------------------------------------------------------
module icr_regfile
  import icr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       clear_i,
  input  logic       pci_mode_i,
  input  logic [1:0] chip_index_i,
  input  logic       re_i,
  input  reg_addr_t  raddr_i,
  input  wr_req_t    wr_i,
  output reg_data_t  rdata_o
);

  logic [RegDepth-1:0] vld_q;
  logic                rvld_q;
  reg_data_t           rdef_q;
  reg_data_t           ram_rdata;

  icr_ram #(
    .Width (RegDataW),
    .Depth (RegDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .re_i    (re_i),
    .raddr_i (raddr_i),
    .rdata_o (ram_rdata),
    .we_i    (wr_i.en),
    .waddr_i (wr_i.addr),
    .wdata_i (wr_i.data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clear_i) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q <= 1'b0;
    end else if (re_i) begin
      rvld_q <= vld_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdef_q <= reg_default(raddr_i, pci_mode_i, chip_index_i);
    end
  end

  assign rdata_o = rvld_q ? ram_rdata : rdef_q;

endmodule

// ===== hdl/ide_controller_config_registers_top.sv =====
// ----------------------------------------------------------------------------
// ide_controller_config_registers_top: dual-channel IDE controller registers
// Index/data port, PCI config access and drive interrupt status handling.
// ----------------------------------------------------------------------------
// One request per clock while in_stall_o is low. A request reads its
// register from the RAM at acceptance, is held in the modify stage, and is
// modified and written back as that stage advances (the single RAM
// read-modify-write sets the rate); its result enters the output register
// at the same edge as the write-back. A back-to-back request that reads the
// entry being written gets the new byte through a forwarding register. The
// result register lets a new request in while an earlier result waits on
// out_stall_i. Reset and configuration writes reload the register file
// through valid bits, so there is no clearing pass; the index register
// survives configuration writes. Configuration is writable only while no
// request is in flight (cfg_ready_o high), and requests are held off while a
// configuration write is offered.
// ----------------------------------------------------------------------------
module ide_controller_config_registers_top
  import icr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write port
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [1:0] cfg_data_i,
  // request channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] kind_i,
  input  logic [7:0] reg_addr_i,
  input  logic [2:0] function_number_i,
  input  logic [7:0] write_data_i,
  input  logic [7:0] irq_status_i,
  input  logic       irq_channel_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic       primary_enable_o,
  output logic       secondary_enable_o,
  output logic       irq14_level_o,
  output logic       irq15_level_o
);

  // straps
  logic       pci_q;
  logic [1:0] chp_q;
  logic [1:0] chip_q;
  logic       cfg_we;

  // architectural flops outside the RAM
  reg_addr_t index_q;
  logic      sec_en_q, sec_en_d;   // mirror of bit 0 of register 0x57
  logic      p_line_q, p_line_d;
  logic      s_line_q, s_line_d;

  // acceptance side
  kind_e     in_kind;
  logic      accept;
  reg_addr_t rd_addr;
  logic      fwd_hit;

  // modify/write-back stage
  logic      s2_valid_q;
  kind_e     s2_kind_q;
  reg_addr_t s2_idx_q;
  reg_addr_t s2_addr_q;
  reg_data_t s2_data_q;
  logic      s2_ch_q;
  logic      s2_fn_ok_q;
  logic      s2_fwd_q;
  reg_data_t s2_fwd_data_q;
  logic      s2_adv;
  reg_data_t rf_rdata;
  reg_data_t cur;
  reg_data_t rd;
  wr_req_t   wr_req;

  // result register
  logic      out_valid_q;
  reg_data_t out_rd_q;
  logic      out_pen_q;
  logic      out_sen_q;
  logic      out_irq14_q;
  logic      out_irq15_q;

  // ---------------------------------------------------------------- straps
  // only with the pipeline empty
  assign cfg_ready_o = !s2_valid_q && !out_valid_q;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pci_q  <= 1'b0;
      chp_q  <= 2'b11;
      chip_q <= 2'b00;
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_PCI_MODE:   pci_q  <= cfg_data_i[0];
        CFG_CHANNELS:   chp_q  <= cfg_data_i;
        CFG_CHIP_INDEX: chip_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // any write within the list is a strap change followed by a device reset
  logic strap_reset;
  assign strap_reset = cfg_we && (cfg_index_i == CFG_PCI_MODE ||
                                  cfg_index_i == CFG_CHANNELS ||
                                  cfg_index_i == CFG_CHIP_INDEX);

  // ------------------------------------------------------------ handshake
  assign s2_adv     = s2_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (s2_valid_q && !s2_adv) || cfg_valid_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_kind    = kind_e'(kind_i);

  // register touched by the request; data writes to 0x50 land in 0x57
  always_comb begin
    rd_addr = index_q;
    case (in_kind)
      KIND_CFG_WR, KIND_CFG_RD: rd_addr = reg_addr_i;
      KIND_IRQ:                 rd_addr = ADDR_CTRL;
      KIND_DATA_WR: begin
        rd_addr = (index_q == ADDR_CTRL) ? ADDR_SEC_EN : index_q;
      end
      default: rd_addr = index_q;
    endcase
  end

  // write-back this cycle to the entry now being read: RAM returns old data
  assign fwd_hit = wr_req.en && (wr_req.addr == rd_addr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q <= '0;
    end else if (accept && in_kind == KIND_IDX_WR) begin
      index_q <= write_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (accept) begin
      s2_valid_q <= 1'b1;
    end else if (s2_adv) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_kind_q     <= in_kind;
      s2_idx_q      <= index_q;
      s2_addr_q     <= rd_addr;
      s2_data_q     <= (in_kind == KIND_IRQ) ? irq_status_i : write_data_i;
      s2_ch_q       <= irq_channel_i;
      s2_fn_ok_q    <= pci_q && (function_number_i == 3'd0);
      s2_fwd_q      <= fwd_hit;
      s2_fwd_data_q <= wr_req.data;
    end
  end

  // --------------------------------------------------------- register file
  icr_regfile u_regfile (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (strap_reset),
    .pci_mode_i   (pci_q),
    .chip_index_i (chip_q),
    .re_i         (accept),
    .raddr_i      (rd_addr),
    .wr_i         (wr_req),
    .rdata_o      (rf_rdata)
  );

  assign cur = s2_fwd_q ? s2_fwd_data_q : rf_rdata;

  // ---------------------------------------------------------- modify stage
  always_comb begin
    wr_req.en   = 1'b0;
    wr_req.addr = s2_addr_q;
    wr_req.data = cur;
    rd          = READ_IDLE;
    sec_en_d    = sec_en_q;
    p_line_d    = p_line_q;
    s_line_d    = s_line_q;
    case (s2_kind_q)
      KIND_DATA_WR: begin
        case (s2_idx_q)
          ADDR_CTRL, ADDR_SEC_EN: begin
            wr_req.en   = 1'b1;
            wr_req.data = {7'b0, s2_data_q[0]};
            sec_en_d    = s2_data_q[0];
          end
          ADDR_CTRL1: begin
            wr_req.en   = 1'b1;
            wr_req.data = s2_data_q & MASK_CTRL1;
          end
          ADDR_TIM0, ADDR_TIM2, ADDR_TIM4, ADDR_TIM5, ADDR_TIM6: begin
            wr_req.en   = 1'b1;
            wr_req.data = s2_data_q;
          end
          ADDR_TIM1, ADDR_TIM3: begin
            wr_req.en   = 1'b1;
            wr_req.data = s2_data_q & MASK_TIMING;
          end
          default: ;
        endcase
      end
      KIND_IDX_RD: rd = s2_idx_q;
      KIND_DATA_RD: begin
        rd = cur;
        // reading the control register acknowledges its interrupt bit
        if (s2_idx_q == ADDR_CTRL) begin
          wr_req.en   = 1'b1;
          wr_req.data = cur & ~MASK_IRQ;
        end
      end
      KIND_CFG_WR: begin
        if (s2_fn_ok_q && s2_addr_q == ADDR_CMD) begin
          wr_req.en   = 1'b1;
          wr_req.data = (cur & MASK_CMD_KEEP) | (s2_data_q & MASK_CMD_WR);
        end else if (s2_fn_ok_q && s2_addr_q == ADDR_STAT_HI) begin
          wr_req.en   = 1'b1;
          wr_req.data = cur & ~(s2_data_q & MASK_W1C);
        end
      end
      KIND_CFG_RD: begin
        if (s2_fn_ok_q) begin
          rd = cur;
        end
      end
      KIND_IRQ: begin
        // a pending interrupt is only overwritten by a new one
        if (!cur[2] || s2_data_q[2]) begin
          wr_req.en   = 1'b1;
          wr_req.data = (cur & ~MASK_IRQ) | s2_data_q;
        end
        if (!s2_ch_q && chp_q[0]) begin
          p_line_d = s2_data_q[2];
        end
        if (s2_ch_q && chp_q[1]) begin
          s_line_d = s2_data_q[2];
        end
      end
      default: ;
    endcase
    wr_req.en = wr_req.en && s2_adv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_en_q <= 1'b1;
      p_line_q <= 1'b0;
      s_line_q <= 1'b0;
    end else if (strap_reset) begin
      sec_en_q <= 1'b1;
      p_line_q <= 1'b0;
      s_line_q <= 1'b0;
    end else if (s2_adv) begin
      sec_en_q <= sec_en_d;
      p_line_q <= p_line_d;
      s_line_q <= s_line_d;
    end
  end

  // -------------------------------------------------------- result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Bit 0 of 0x04 resets to one and no access can clear it, so the decode
  // gate (not PCI, or 0x04 bit 0) is always open.
  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_rd_q    <= rd;
      out_pen_q   <= chp_q[0];
      out_sen_q   <= chp_q[1] && sec_en_d;
      out_irq14_q <= p_line_d;
      out_irq15_q <= s_line_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign read_data_o        = out_rd_q;
  assign primary_enable_o   = out_pen_q;
  assign secondary_enable_o = out_sen_q;
  assign irq14_level_o      = out_irq14_q;
  assign irq15_level_o      = out_irq15_q;

endmodule
